FILE: rtl/atrlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atrlc_pkg;

    localparam int MAX_LINE = 512;
    localparam int POS_W    = $clog2(MAX_LINE + 1);
    localparam int NPAT     = 8;

    localparam int PAT_OK      = 0;
    localparam int PAT_ERROR   = 1;
    localparam int PAT_BOOT    = 2;
    localparam int PAT_DFU_OK  = 3;
    localparam int PAT_DFU_ERR = 4;
    localparam int PAT_TX      = 5;
    localparam int PAT_DFU     = 6;
    localparam int PAT_PLUS    = 7;

    localparam logic [NPAT-1:0] EXACT_MASK = 8'h05;

    localparam logic [63:0] PAT_TEXT [NPAT] = '{
        {"+OK", 40'h0},
        {"+ERROR=", 8'h0},
        "+BOOT=OK",
        {"+DFU=OK", 8'h0},
        "+DFU=ERR",
        {"+TX=", 32'h0},
        {"+DFU=", 24'h0},
        {"+", 56'h0}
    };
    localparam logic [3:0] PAT_LEN [NPAT] = '{
        4'd3, 4'd7, 4'd8, 4'd7, 4'd8, 4'd4, 4'd5, 4'd1
    };

    localparam logic [15:0] STATUS_NONE = 16'hFFFF;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_ARM   = 2'd2;

    localparam logic [3:0] FLAG_OK   = 4'b0001;
    localparam logic [3:0] FLAG_ERR  = 4'b0010;
    localparam logic [3:0] FLAG_DATA = 4'b0100;
    localparam logic [3:0] FLAG_TXC  = 4'b1000;

    localparam int FLAG_OK_BIT   = 0;
    localparam int FLAG_ERR_BIT  = 1;
    localparam int FLAG_DATA_BIT = 2;
    localparam int FLAG_TXC_BIT  = 3;

    typedef enum logic [2:0] {
        KIND_IGNORED,
        KIND_OK,
        KIND_ERROR,
        KIND_BOOT_OK,
        KIND_DFU_OK,
        KIND_DFU_ERR,
        KIND_TX,
        KIND_GENERIC
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_DIGIT,
        PH_DIGITS,
        PH_STOPPED,
        PH_COMMA
    } t_phase;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [NPAT-1:0]  match;
        logic             cr_pending;
        logic             equals_seen;
        logic [15:0]      acc;
        t_phase           phase;
    } t_line;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic        line_end;
        t_kind       line_kind;
        logic        resp_ok;
        logic        resp_error;
        logic        data_ready;
        logic        tx_complete;
        logic [15:0] tx_status;
        logic        overflow;
    } t_out;

    function automatic t_line line_clear();
        t_line r;
        r.pos         = '0;
        r.match       = '1;
        r.cr_pending  = 1'b0;
        r.equals_seen = 1'b0;
        r.acc         = '0;
        r.phase       = PH_IDLE;
        return r;
    endfunction

    // append one content character at index i
    function automatic t_line feed(t_line s, logic [POS_W-1:0] i, logic [7:0] c);
        t_line       r;
        logic [63:0] row;
        logic        digit;
        logic [19:0] v;
        r = s;
        for (int k = 0; k < NPAT; k++) begin
            if (r.match[k]) begin
                if (i < POS_W'(PAT_LEN[k])) begin
                    row = PAT_TEXT[k] << {i[2:0], 3'b000};
                    if (c != row[63:56]) begin
                        r.match[k] = 1'b0;
                    end
                end else if (EXACT_MASK[k]) begin
                    r.match[k] = 1'b0;
                end
            end
        end
        if (c == CH_EQ) begin
            r.equals_seen = 1'b1;
        end
        digit = (c >= CH_0) && (c <= CH_9);
        v = {4'b0000, r.acc} * 20'd10 + {16'h0000, c[3:0]};
        if (i >= POS_W'(4) && r.phase != PH_IDLE && r.phase != PH_COMMA) begin
            if (c == CH_COMMA) begin
                if (r.phase == PH_WAIT_DIGIT) begin
                    r.acc = STATUS_NONE;
                end
                r.phase = PH_COMMA;
            end else if (r.phase == PH_WAIT_DIGIT) begin
                if (digit) begin
                    r.acc   = {12'h000, c[3:0]};
                    r.phase = PH_DIGITS;
                end else begin
                    r.acc   = STATUS_NONE;
                    r.phase = PH_STOPPED;
                end
            end else if (r.phase == PH_DIGITS) begin
                if (digit) begin
                    r.acc = (v > {4'b0000, STATUS_NONE}) ? STATUS_NONE : v[15:0];
                end else begin
                    r.phase = PH_STOPPED;
                end
            end
        end
        if (i == POS_W'(3) && r.match[PAT_TX]) begin
            r.phase = PH_WAIT_DIGIT;
            r.acc   = '0;
        end
        return r;
    endfunction

    function automatic logic matched(t_line s, int k, logic [POS_W-1:0] n);
        if (!s.match[k]) begin
            return 1'b0;
        end
        if (EXACT_MASK[k]) begin
            return n == POS_W'(PAT_LEN[k]);
        end
        return n >= POS_W'(PAT_LEN[k]);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/atrlc_step.sv
`timescale 1ns / 1ps
`default_nettype none

module atrlc_step (
    input  wire atrlc_pkg::t_line i_line,
    input  wire logic [3:0]       i_flags,
    input  wire logic [15:0]      i_status,
    input  wire atrlc_pkg::t_in   i_item,
    output atrlc_pkg::t_line      o_line,
    output logic [3:0]            o_flags,
    output logic [15:0]           o_status,
    output atrlc_pkg::t_out       o_result
);

    atrlc_pkg::t_line                base;
    atrlc_pkg::t_line                s;
    logic [atrlc_pkg::POS_W-1:0]     n;
    logic                            ovf;
    logic                            line_end;
    atrlc_pkg::t_kind                kind;

    always_comb begin
        o_line   = i_line;
        o_flags  = i_flags;
        o_status = i_status;
        base     = i_line;
        s        = i_line;
        n        = '0;
        ovf      = 1'b0;
        line_end = 1'b0;
        kind     = atrlc_pkg::KIND_IGNORED;
        unique case (i_item.operation)
            atrlc_pkg::OP_CLEAR: begin
                o_flags = i_flags & ~(atrlc_pkg::FLAG_OK | atrlc_pkg::FLAG_ERR
                                      | atrlc_pkg::FLAG_DATA);
            end
            atrlc_pkg::OP_ARM: begin
                o_flags  = i_flags & ~atrlc_pkg::FLAG_TXC;
                o_status = atrlc_pkg::STATUS_NONE;
            end
            atrlc_pkg::OP_RX: begin
                if (i_line.pos >= atrlc_pkg::POS_W'(atrlc_pkg::MAX_LINE)) begin
                    base = atrlc_pkg::line_clear();
                    ovf  = 1'b1;
                end
                if (i_item.rx_byte == atrlc_pkg::CH_LF) begin
                    n = base.pos - atrlc_pkg::POS_W'(base.cr_pending);
                    if (n != '0) begin
                        line_end = 1'b1;
                        if (!atrlc_pkg::matched(base, atrlc_pkg::PAT_PLUS, n)) begin
                            kind = atrlc_pkg::KIND_IGNORED;
                        end else if (atrlc_pkg::matched(base, atrlc_pkg::PAT_OK, n)) begin
                            kind    = atrlc_pkg::KIND_OK;
                            o_flags = i_flags | atrlc_pkg::FLAG_OK;
                        end else if (atrlc_pkg::matched(base, atrlc_pkg::PAT_ERROR, n)) begin
                            kind    = atrlc_pkg::KIND_ERROR;
                            o_flags = i_flags | atrlc_pkg::FLAG_OK | atrlc_pkg::FLAG_ERR;
                        end else if (atrlc_pkg::matched(base, atrlc_pkg::PAT_BOOT, n)) begin
                            kind    = atrlc_pkg::KIND_BOOT_OK;
                            o_flags = i_flags | atrlc_pkg::FLAG_OK;
                        end else if (atrlc_pkg::matched(base, atrlc_pkg::PAT_DFU, n)) begin
                            if (atrlc_pkg::matched(base, atrlc_pkg::PAT_DFU_OK, n)) begin
                                kind    = atrlc_pkg::KIND_DFU_OK;
                                o_flags = i_flags | atrlc_pkg::FLAG_OK;
                            end else if (atrlc_pkg::matched(base, atrlc_pkg::PAT_DFU_ERR,
                                                            n)) begin
                                kind    = atrlc_pkg::KIND_DFU_ERR;
                                o_flags = i_flags | atrlc_pkg::FLAG_OK
                                          | atrlc_pkg::FLAG_ERR;
                            end
                        end else if (atrlc_pkg::matched(base, atrlc_pkg::PAT_TX, n)) begin
                            kind = atrlc_pkg::KIND_TX;
                            if (base.phase == atrlc_pkg::PH_COMMA) begin
                                o_status = base.acc;
                            end
                            o_flags = i_flags | atrlc_pkg::FLAG_TXC | atrlc_pkg::FLAG_OK;
                        end else if (base.equals_seen) begin
                            kind    = atrlc_pkg::KIND_GENERIC;
                            o_flags = i_flags | atrlc_pkg::FLAG_DATA;
                        end
                    end
                    o_line = atrlc_pkg::line_clear();
                end else begin
                    s = base;
                    // a held cr turns out to be line content
                    if (s.cr_pending) begin
                        s = atrlc_pkg::feed(s, s.pos - atrlc_pkg::POS_W'(1), atrlc_pkg::CH_CR);
                        s.cr_pending = 1'b0;
                    end
                    if (i_item.rx_byte == atrlc_pkg::CH_CR) begin
                        s.cr_pending = 1'b1;
                    end else begin
                        s = atrlc_pkg::feed(s, s.pos, i_item.rx_byte);
                    end
                    s.pos  = s.pos + atrlc_pkg::POS_W'(1);
                    o_line = s;
                end
            end
            default: begin
            end
        endcase
        o_result.line_end    = line_end;
        o_result.line_kind   = kind;
        o_result.resp_ok     = o_flags[atrlc_pkg::FLAG_OK_BIT];
        o_result.resp_error  = o_flags[atrlc_pkg::FLAG_ERR_BIT];
        o_result.data_ready  = o_flags[atrlc_pkg::FLAG_DATA_BIT];
        o_result.tx_complete = o_flags[atrlc_pkg::FLAG_TXC_BIT];
        o_result.tx_status   = o_status;
        o_result.overflow    = ovf;
    end

endmodule

`default_nettype wire

FILE: rtl/at_response_line_classifier.sv
// an accepted transaction's result is on the output register in the next cycle
// throughput: one transaction per cycle while the input does not stall, set by the
// combinational byte classifier; input stalls only while a result is held and the output side stalls
// synchronous active-low reset: empty line, all match flags set, response flags clear,
// tx status 65535, output empty
`timescale 1ns / 1ps
`default_nettype none

module at_response_line_classifier (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire atrlc_pkg::t_in  i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output atrlc_pkg::t_out      o_out
);

    atrlc_pkg::t_line r_line;
    logic [3:0]       r_flags;
    logic [15:0]      r_status;
    logic             r_out_valid;
    atrlc_pkg::t_out  r_out;

    atrlc_pkg::t_line n_line;
    logic [3:0]       n_flags;
    logic [15:0]      n_status;
    atrlc_pkg::t_out  n_out;

    logic w_accept;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    atrlc_step u_step (
        .i_line   (r_line),
        .i_flags  (r_flags),
        .i_status (r_status),
        .i_item   (i_in),
        .o_line   (n_line),
        .o_flags  (n_flags),
        .o_status (n_status),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= atrlc_pkg::line_clear();
            r_flags     <= '0;
            r_status    <= atrlc_pkg::STATUS_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_line      <= n_line;
                r_flags     <= n_flags;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    a_ovf_no_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.overflow |-> !r_out.line_end)
        else $error("overflow reported together with a completed line");

    a_kind_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.line_end |-> r_out.line_kind == atrlc_pkg::KIND_IGNORED)
        else $error("line kind set without line end");

    a_err_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags[atrlc_pkg::FLAG_ERR_BIT] |-> r_flags[atrlc_pkg::FLAG_OK_BIT])
        else $error("error flag set without response finished flag");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line.pos <= atrlc_pkg::POS_W'(atrlc_pkg::MAX_LINE))
        else $error("line position beyond length limit");

endmodule

`default_nettype wire
